// ===== rtl/core/five_tuple_first_match_filter_defines.svh =====
// Assertion macros for the five-tuple filter checker.
// Clocked on clk_i, disabled while rst_ni is low.
`ifndef FIVE_TUPLE_FIRST_MATCH_FILTER_DEFINES_SVH
`define FIVE_TUPLE_FIRST_MATCH_FILTER_DEFINES_SVH

// Check a property on every clock edge out of reset.
`define FMF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define FMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/fmf_pkg.sv =====
// Shared types and constants for the five-tuple first-match filter.
// Used by every module of the block but fmf_ram; depends on nothing.
`default_nettype none
package fmf_pkg;

  localparam int RULE_SLOTS = 128;
  localparam int IDX_W      = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int CNT_W      = IDX_W + 1;
  localparam int SLOT_W     = 7;

  localparam logic [15:0] ETH_VLAN = 16'h8100;
  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
  localparam logic [1:0] VERDICT_DROP   = 2'd1;
  localparam logic [1:0] VERDICT_RATE   = 2'd2;
  localparam logic [1:0] VERDICT_NONE   = 2'd3;

  // One rule, as stored in the rule RAM; also the key of a scan.
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
    logic [1:0]  verdict;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

  // One job handed from the parser to the rule engine.
  typedef struct packed {
    logic              is_write;  // 1 rule write, 0 packet verdict
    logic              flag;      // write: present; packet: parsed ok
    logic [SLOT_W-1:0] slot;
    rule_t             rule;
  } job_t;

  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } bk_state_e;

endpackage
`default_nettype wire

// ===== rtl/core/fmf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
`default_nettype none
module fmf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/fmf_front.sv =====
// Packet byte parser and rule write classifier of the five-tuple filter.
// Depends on fmf_pkg; emits one job per rule write or finished packet.
`default_nettype none
module fmf_front import fmf_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire logic              kind_i,
  input  wire logic [7:0]        pkt_byte_i,
  input  wire logic              pkt_last_i,
  input  wire logic [SLOT_W-1:0] rule_slot_i,
  input  wire logic              rule_present_i,
  input  wire logic [31:0]       rule_source_addr_i,
  input  wire logic [31:0]       rule_dest_addr_i,
  input  wire logic [7:0]        rule_proto_i,
  input  wire logic [15:0]       rule_source_port_i,
  input  wire logic [15:0]       rule_dest_port_i,
  input  wire logic [1:0]        rule_verdict_i,
  input  wire logic              q_full_i,
  output      logic              push_o,
  output      job_t              job_o
);

  logic [7:0]  pos_q, pos_d;
  logic [15:0] outer_q, outer_d;
  logic [15:0] inner_q, inner_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;
  logic [15:0] sport_q, sport_d;
  logic [15:0] dport_q, dport_d;

  logic [7:0]  ipoff;
  logic [7:0]  off;
  logic [8:0]  len;
  logic [8:0]  ipoff_d;
  logic [15:0] etype;
  logic        is_vlan;
  logic        parsed_ok;
  logic        accept;
  logic        slot_ok;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign slot_ok    = (int'(rule_slot_i) < RULE_SLOTS);

  // Capture header fields of the current byte
  always_comb begin
    outer_d = outer_q;
    inner_d = inner_q;
    proto_d = proto_q;
    src_d   = src_q;
    dst_d   = dst_q;
    sport_d = sport_q;
    dport_d = dport_q;
    ipoff   = (outer_q == ETH_VLAN) ? 8'd18 : 8'd14;
    off     = pos_q - ipoff;
    if (pos_q == 8'd12 || pos_q == 8'd13) begin
      outer_d = {outer_q[7:0], pkt_byte_i};
    end else begin
      if (pos_q == 8'd16 || pos_q == 8'd17) begin
        inner_d = {inner_q[7:0], pkt_byte_i};
      end
      if (pos_q >= 8'd14 && pos_q >= ipoff) begin
        if (off == 8'd9) begin
          proto_d = pkt_byte_i;
        end else if (off >= 8'd12 && off <= 8'd15) begin
          src_d = {src_q[23:0], pkt_byte_i};
        end else if (off >= 8'd16 && off <= 8'd19) begin
          dst_d = {dst_q[23:0], pkt_byte_i};
        end else if (off >= 8'd20 && off <= 8'd21) begin
          sport_d = {sport_q[7:0], pkt_byte_i};
        end else if (off >= 8'd22 && off <= 8'd23) begin
          dport_d = {dport_q[7:0], pkt_byte_i};
        end
      end
    end
  end

  // Classify the packet as it stands after this byte
  always_comb begin
    len       = {1'b0, pos_q} + 9'd1;
    is_vlan   = (outer_d == ETH_VLAN);
    ipoff_d   = is_vlan ? 9'd18 : 9'd14;
    etype     = is_vlan ? inner_d : outer_d;
    parsed_ok = 1'b1;
    if (len < 9'd14 || (is_vlan && len < 9'd18)) begin
      parsed_ok = 1'b0;
    end else if (etype != ETH_IPV4 || len < ipoff_d + 9'd20 ||
                 (proto_d == PROTO_UDP && len < ipoff_d + 9'd28) ||
                 (proto_d == PROTO_TCP && len < ipoff_d + 9'd40)) begin
      parsed_ok = 1'b0;
    end
  end

  // Build the job for the rule engine
  always_comb begin
    push_o = accept && (kind_i ? slot_ok : pkt_last_i);
    job_o.is_write = kind_i;
    job_o.slot     = rule_slot_i;
    if (kind_i) begin
      job_o.flag         = rule_present_i;
      job_o.rule.src     = rule_source_addr_i;
      job_o.rule.dst     = rule_dest_addr_i;
      job_o.rule.sport   = rule_source_port_i;
      job_o.rule.dport   = rule_dest_port_i;
      job_o.rule.proto   = rule_proto_i;
      job_o.rule.verdict = rule_verdict_i;
    end else begin
      job_o.flag         = parsed_ok;
      job_o.rule.src     = src_d;
      job_o.rule.dst     = dst_d;
      job_o.rule.proto   = proto_d;
      job_o.rule.verdict = VERDICT_NONE;
      if (proto_d == PROTO_UDP || proto_d == PROTO_TCP) begin
        job_o.rule.sport = sport_d;
        job_o.rule.dport = dport_d;
      end else begin
        job_o.rule.sport = '0;
        job_o.rule.dport = '0;
      end
    end
  end

  // Advance the capture state; clear it at the end of a packet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      outer_q <= '0;
      inner_q <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      sport_q <= '0;
      dport_q <= '0;
    end else if (accept && !kind_i) begin
      if (pkt_last_i) begin
        pos_q   <= '0;
        outer_q <= '0;
        inner_q <= '0;
        proto_q <= '0;
        src_q   <= '0;
        dst_q   <= '0;
        sport_q <= '0;
        dport_q <= '0;
      end else begin
        pos_q   <= (pos_q == 8'hFF) ? pos_q : pos_q + 8'd1;
        outer_q <= outer_d;
        inner_q <= inner_d;
        proto_q <= proto_d;
        src_q   <= src_d;
        dst_q   <= dst_d;
        sport_q <= sport_d;
        dport_q <= dport_d;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/fmf_queue.sv =====
// Two-entry job queue between the parser and the rule engine.
// Depends on fmf_pkg for the job type.
`default_nettype none
module fmf_queue import fmf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  output      logic full_o,
  input  wire logic pop_i,
  output      logic valid_o,
  output      job_t head_o
);

  job_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = slot_q[rd_ptr_q];

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/fmf_back.sv =====
// Rule engine of the five-tuple filter: applies rule writes and scans rules.
// Depends on fmf_pkg and fmf_ram; drives the result register.
`default_nettype none
module fmf_back import fmf_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  wire job_t              q_head_i,
  output      logic              pop_o,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      logic              drop_packet_o,
  output      logic              parsed_ok_o,
  output      logic              hit_o,
  output      logic [SLOT_W-1:0] hit_slot_o
);

  bk_state_e state_q, state_d;

  logic [RULE_SLOTS-1:0] valid_q;
  logic [CNT_W-1:0]      rd_idx_q, rd_idx_d;
  logic                  cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]      cmp_idx_q, cmp_idx_d;
  rule_t                 key_q;
  rule_t                 rdata;

  logic             issue;
  logic             match;
  logic             take_write;
  logic             take_pkt;
  logic             scan_done;
  logic             load_out;
  logic             res_drop, res_parsed, res_hit;
  logic [IDX_W-1:0] res_slot;
  logic [IDX_W-1:0] wr_idx;

  assign wr_idx = IDX_W'(q_head_i.slot);

  fmf_ram #(
    .Width(RULE_W),
    .Depth(RULE_SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (take_write && q_head_i.flag),
    .waddr_i(wr_idx),
    .wdata_i(q_head_i.rule),
    .re_i   (issue),
    .raddr_i(rd_idx_q[IDX_W-1:0]),
    .rdata_o(rdata)
  );

  // Fetch the next slot while it is in range and valid
  assign issue = (state_q == BK_SCAN) && (rd_idx_q < CNT_W'(RULE_SLOTS)) &&
                 valid_q[rd_idx_q[IDX_W-1:0]];

  // Compare the fetched rule against the packet key
  assign match = cmp_vld_q &&
                 (rdata.src == '0 || rdata.src == key_q.src) &&
                 (rdata.dst == '0 || rdata.dst == key_q.dst) &&
                 (rdata.proto == key_q.proto) &&
                 (rdata.sport == '0 || rdata.sport == key_q.sport) &&
                 (rdata.dport == '0 || rdata.dport == key_q.dport) &&
                 (rdata.verdict != VERDICT_NONE);

  assign scan_done  = (state_q == BK_SCAN) && (match || (!issue && !cmp_vld_q));
  assign take_write = (state_q == BK_IDLE) && q_valid_i && q_head_i.is_write;
  assign take_pkt   = (state_q == BK_IDLE) && q_valid_i && !q_head_i.is_write &&
                      !out_valid_o;
  assign pop_o      = take_write || take_pkt;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (take_pkt && q_head_i.flag) begin
          state_d = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (scan_done) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Scan pointers and result selection
  always_comb begin
    rd_idx_d   = rd_idx_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    load_out   = 1'b0;
    res_drop   = 1'b0;
    res_parsed = 1'b0;
    res_hit    = 1'b0;
    res_slot   = '0;
    case (state_q)
      BK_IDLE: begin
        rd_idx_d = '0;
        if (take_pkt && !q_head_i.flag) begin
          load_out = 1'b1;
        end
      end
      BK_SCAN: begin
        if (issue) begin
          rd_idx_d = rd_idx_q + CNT_W'(1);
        end
        cmp_vld_d  = issue && !scan_done;
        cmp_idx_d  = rd_idx_q[IDX_W-1:0];
        res_parsed = 1'b1;
        if (scan_done) begin
          load_out = 1'b1;
          if (match) begin
            res_hit  = 1'b1;
            res_slot = cmp_idx_q;
            res_drop = (rdata.verdict == VERDICT_DROP);
          end
        end
      end
      default: begin
        rd_idx_d = '0;
      end
    endcase
  end

  // Control registers, slot valid bits and result handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      rd_idx_q    <= '0;
      cmp_vld_q   <= 1'b0;
      valid_q     <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_idx_q  <= rd_idx_d;
      cmp_vld_q <= cmp_vld_d;
      if (take_write) begin
        valid_q[wr_idx] <= q_head_i.flag;
      end
      if (load_out) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Hold the scan key and the result payload
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    if (take_pkt) begin
      key_q <= q_head_i.rule;
    end
    if (load_out) begin
      drop_packet_o <= res_drop;
      parsed_ok_o   <= res_parsed;
      hit_o         <= res_hit;
      hit_slot_o    <= SLOT_W'(res_slot);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/five_tuple_first_match_filter.sv =====
// Flow: each job passes the job queue; the rule engine registers an unparsed packet's result
// directly, a parsed one's after scanning valid slots from slot 0 to the first deciding rule,
// invalid slot or the end. Throughput: one byte or rule write per cycle while the queue is not
// full; the back end holds a packet until its result loads and takes none while a result waits
// (single rule RAM read port). Reset: rst_ni clears slot valid bits, parser capture and queue.
// Top level of the five-tuple filter; depends on fmf_pkg, fmf_front, fmf_queue, fmf_back.
`default_nettype none
module five_tuple_first_match_filter import fmf_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire logic              kind_i,
  input  wire logic [7:0]        pkt_byte_i,
  input  wire logic              pkt_last_i,
  input  wire logic [SLOT_W-1:0] rule_slot_i,
  input  wire logic              rule_present_i,
  input  wire logic [31:0]       rule_source_addr_i,
  input  wire logic [31:0]       rule_dest_addr_i,
  input  wire logic [7:0]        rule_proto_i,
  input  wire logic [15:0]       rule_source_port_i,
  input  wire logic [15:0]       rule_dest_port_i,
  input  wire logic [1:0]        rule_verdict_i,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      logic              drop_packet_o,
  output      logic              parsed_ok_o,
  output      logic              hit_o,
  output      logic [SLOT_W-1:0] hit_slot_o
);

  logic push, q_full, q_valid, pop;
  job_t push_job, head_job;

  fmf_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .kind_i            (kind_i),
    .pkt_byte_i        (pkt_byte_i),
    .pkt_last_i        (pkt_last_i),
    .rule_slot_i       (rule_slot_i),
    .rule_present_i    (rule_present_i),
    .rule_source_addr_i(rule_source_addr_i),
    .rule_dest_addr_i  (rule_dest_addr_i),
    .rule_proto_i      (rule_proto_i),
    .rule_source_port_i(rule_source_port_i),
    .rule_dest_port_i  (rule_dest_port_i),
    .rule_verdict_i    (rule_verdict_i),
    .q_full_i          (q_full),
    .push_o            (push),
    .job_o             (push_job)
  );

  fmf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .head_o (head_job)
  );

  fmf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_head_i     (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .drop_packet_o(drop_packet_o),
    .parsed_ok_o  (parsed_ok_o),
    .hit_o        (hit_o),
    .hit_slot_o   (hit_slot_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/fmf_checker.sv =====
// Port-level checks on the five-tuple filter result channel.
// Depends on fmf_pkg and the defines header; bound to the top level below.
`default_nettype none
`include "five_tuple_first_match_filter_defines.svh"
module fmf_checker import fmf_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic              drop_packet_o,
  input wire logic              parsed_ok_o,
  input wire logic              hit_o,
  input wire logic [SLOT_W-1:0] hit_slot_o
);

  // A miss reports slot zero
  `FMF_ASSERT(a_miss_slot_zero, !(out_valid_o && !hit_o) || hit_slot_o == '0, "miss with slot")

  // A hit only happens on a parsed packet
  `FMF_ASSERT(a_hit_parsed, !(out_valid_o && hit_o) || parsed_ok_o, "hit on unparsed packet")

  // Only a deciding rule drops a packet
  `FMF_ASSERT(a_drop_hit, !(out_valid_o && drop_packet_o) || hit_o, "drop without hit")

  // A stalled result holds
  `FMF_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(hit_slot_o) && $stable(drop_packet_o), "result changed under stall")

endmodule

bind five_tuple_first_match_filter fmf_checker u_fmf_checker (.*);
`default_nettype wire
